// File: src/lir4_pkg.sv
// Shared types and constants for the fourth-order Linkwitz-Riley highpass filter.
// No dependencies; the interfaces, the datapath, the top and the testbench import this package.
`timescale 1ns / 1ps

package lir4_pkg;

   // Coefficients are Q4.20 two's complement
   localparam int COEF_W     = 24;
   localparam int COEF_FRAC  = 20;
   localparam int NUM_COEFS  = 7;
   localparam int TAPS       = 4;
   localparam int CHAN_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COEF_W;

   // Register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A0 = 3'd0,
      CSR_A1 = 3'd1,
      CSR_A2 = 3'd2,
      CSR_B1 = 3'd3,
      CSR_B2 = 3'd4,
      CSR_B3 = 3'd5,
      CSR_B4 = 3'd6
   } csr_index_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   typedef struct packed {
      coef_type a0;
      coef_type a1;
      coef_type a2;
      coef_type b1;
      coef_type b2;
      coef_type b3;
      coef_type b4;
   } coef_set_type;

   // Control tag that travels with each item down the pipeline
   typedef struct packed {
      logic              valid;
      logic              in_range;
      logic [CHAN_W-1:0] channel;
   } tag_type;

endpackage

// File: src/lir4_if.sv
// Valid/ready channel interfaces for the filter's request and response items.
// Depends on lir4_pkg for the channel field width.
`timescale 1ns / 1ps

interface lir4_req_if import lir4_pkg::*; #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic [CHAN_W-1:0]             channel;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output channel, output sample_in, input ready);
   modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface lir4_rsp_if import lir4_pkg::*; #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic [CHAN_W-1:0]             channel_out;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output channel_out, output sample_out, input ready);
   modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

// File: src/lir4_hist_mem.sv
// Per-channel history memory: one row holds four past inputs and four past outputs.
// Registered read with write-to-read bypass; row valid bits make unwritten rows read zero.
`timescale 1ns / 1ps

module lir4_hist_mem #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3,
   parameter int ROW_W  = 192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ROW_W-1:0]  rd_row,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_row
);

   logic [ROW_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] row_valid_ff;
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_valid_ff;
   logic             bypass;

   assign bypass = wr_en && (wr_addr == rd_addr);

   // Storage and read data register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff <= bypass ? wr_row : mem[rd_addr];
      end
   end

   // Row valid bits: a row never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= bypass || row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: src/lir4_datapath.sv
// Filter arithmetic pipeline: pre-add, seven parallel multiplies, partial sums,
// final sum with rounding and saturation into the response register. Uses lir4_pkg.
`timescale 1ns / 1ps

module lir4_datapath import lir4_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  tag_type                       in_tag,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   input  coef_set_type                  coefs,
   input  logic [8*SAMPLE_BITS-1:0]      hist_row,
   output tag_type                       s1_tag,
   output tag_type                       s2_tag,
   output tag_type                       s3_tag,
   output tag_type                       wr_tag,
   output logic                          wr_en,
   output logic [8*SAMPLE_BITS-1:0]      wr_row,
   output logic                          out_valid,
   output logic [CHAN_W-1:0]             out_channel,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   localparam int SB     = SAMPLE_BITS;
   localparam int PRE_W  = SB + 1;
   localparam int PROD_W = COEF_W + PRE_W;
   localparam int ACC_W  = PROD_W + 3;
   localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SB - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   typedef logic signed [SB-1:0]     smp_type;
   typedef logic signed [PRE_W-1:0]  pre_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // History values needed to build the shifted row at write-back
   typedef struct packed {
      smp_type x0;
      smp_type x1;
      smp_type x2;
      smp_type x3;
      smp_type y1;
      smp_type y2;
      smp_type y3;
   } carry_type;

   // Stage 1: item registers, aligned with the memory read data
   tag_type   s1_tag_ff;
   smp_type   s1_x_ff;
   smp_type   h_x [TAPS];
   smp_type   h_y [TAPS];

   // Stage 2: pre-added operands
   tag_type   s2_tag_ff;
   pre_type   s2_sa_ff;
   pre_type   s2_sb_ff;
   smp_type   s2_x2_ff;
   smp_type   s2_y_ff [TAPS];
   carry_type s2_carry_ff;

   // Stage 3: products
   tag_type   s3_tag_ff;
   prod_type  s3_p_ff [NUM_COEFS];
   carry_type s3_carry_ff;

   // Stage 4: partial sums
   tag_type   s4_tag_ff;
   acc_type   s4_part0_ff;
   acc_type   s4_part1_ff;
   carry_type s4_carry_ff;

   // Output register
   logic      out_valid_ff;
   logic [CHAN_W-1:0] out_channel_ff;
   smp_type   out_sample_ff;

   acc_type   acc_sum;
   acc_type   acc_rnd;
   acc_type   acc_shr;
   acc_type   acc_sat;
   smp_type   y_new;

   // Unpack the history row: x1..x4 low, y1..y4 high
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         h_x[k] = hist_row[k*SB +: SB];
         h_y[k] = hist_row[(TAPS+k)*SB +: SB];
      end
   end

   // Control tags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff    <= '0;
         s2_tag_ff    <= '0;
         s3_tag_ff    <= '0;
         s4_tag_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_tag_ff    <= in_tag;
         s2_tag_ff    <= s1_tag_ff;
         s3_tag_ff    <= s2_tag_ff;
         s4_tag_ff    <= s3_tag_ff;
         out_valid_ff <= s4_tag_ff.valid;
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff <= in_sample;

         s2_sa_ff <= PRE_W'(s1_x_ff) + PRE_W'(h_x[3]);
         s2_sb_ff <= PRE_W'(h_x[0]) + PRE_W'(h_x[2]);
         s2_x2_ff <= h_x[1];
         for (int k = 0; k < TAPS; k++) begin
            s2_y_ff[k] <= h_y[k];
         end
         s2_carry_ff <= '{x0: s1_x_ff, x1: h_x[0], x2: h_x[1], x3: h_x[2],
                          y1: h_y[0], y2: h_y[1], y3: h_y[2]};

         s3_p_ff[0]  <= coefs.a0 * s2_sa_ff;
         s3_p_ff[1]  <= coefs.a1 * s2_sb_ff;
         s3_p_ff[2]  <= coefs.a2 * s2_x2_ff;
         s3_p_ff[3]  <= coefs.b1 * s2_y_ff[0];
         s3_p_ff[4]  <= coefs.b2 * s2_y_ff[1];
         s3_p_ff[5]  <= coefs.b3 * s2_y_ff[2];
         s3_p_ff[6]  <= coefs.b4 * s2_y_ff[3];
         s3_carry_ff <= s2_carry_ff;

         s4_part0_ff <= ACC_W'(s3_p_ff[0]) + ACC_W'(s3_p_ff[1])
                        + ACC_W'(s3_p_ff[2]) - ACC_W'(s3_p_ff[3]);
         s4_part1_ff <= -ACC_W'(s3_p_ff[4]) - ACC_W'(s3_p_ff[5]) - ACC_W'(s3_p_ff[6]);
         s4_carry_ff <= s3_carry_ff;

         out_channel_ff <= s4_tag_ff.channel;
         out_sample_ff  <= s4_tag_ff.in_range ? y_new : '0;
      end
   end

   // Final sum, round half up by 2^-20, saturate to the sample range
   always_comb begin
      acc_sum = s4_part0_ff + s4_part1_ff;
      acc_rnd = acc_sum + HALF;
      acc_shr = acc_rnd >>> COEF_FRAC;
      if (acc_shr > SAT_HI) begin
         acc_sat = SAT_HI;
      end else if (acc_shr < SAT_LO) begin
         acc_sat = SAT_LO;
      end else begin
         acc_sat = acc_shr;
      end
      y_new = acc_sat[SB-1:0];
   end

   // Write-back of the shifted histories
   assign wr_en  = advance && s4_tag_ff.valid && s4_tag_ff.in_range;
   assign wr_tag = s4_tag_ff;
   assign wr_row = {s4_carry_ff.y3, s4_carry_ff.y2, s4_carry_ff.y1, y_new,
                    s4_carry_ff.x3, s4_carry_ff.x2, s4_carry_ff.x1, s4_carry_ff.x0};

   assign s1_tag      = s1_tag_ff;
   assign s2_tag      = s2_tag_ff;
   assign s3_tag      = s3_tag_ff;
   assign out_valid   = out_valid_ff;
   assign out_channel = out_channel_ff;
   assign out_sample  = out_sample_ff;

endmodule

// File: src/linkwitz_riley4_highpass_iir_top.sv
// Multichannel fourth-order Linkwitz-Riley highpass IIR, direct form I, per-channel state in memory.
// Pipeline: the history read is registered at the accept edge together with the item, then
// pre-add, multiply, partial sums, and final sum with round and saturation into rsp_chan.
// Throughput: one item per cycle while rsp_chan is not backed up and the channel differs from the
// previous three items; a repeated channel stalls, set by the read-compute-write loop through the history memory.
// Reset (synchronous): coefficients to zero, pipeline emptied, all histories read as zero through
// row valid bits; no clearing pass, items are accepted as soon as reset is released.
`timescale 1ns / 1ps

module linkwitz_riley4_highpass_iir_top import lir4_pkg::*; #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   lir4_req_if.sink              req_chan,
   lir4_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ROW_W  = 2 * TAPS * SAMPLE_BITS;

   coef_set_type     coef_ff;
   tag_type          in_tag;
   tag_type          s1_tag;
   tag_type          s2_tag;
   tag_type          s3_tag;
   tag_type          wr_tag;
   logic             advance;
   logic             hazard;
   logic             accept;
   logic             in_range;
   logic             wr_en;
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] wr_row;

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_A0:  coef_ff.a0 <= csr_wr_data;
            CSR_A1:  coef_ff.a1 <= csr_wr_data;
            CSR_A2:  coef_ff.a2 <= csr_wr_data;
            CSR_B1:  coef_ff.b1 <= csr_wr_data;
            CSR_B2:  coef_ff.b2 <= csr_wr_data;
            CSR_B3:  coef_ff.b3 <= csr_wr_data;
            CSR_B4:  coef_ff.b4 <= csr_wr_data;
            default: coef_ff    <= coef_ff;
         endcase
      end
   end

   // Same-channel interlock: stall while an item of this channel has not yet reached write-back
   function automatic logic tag_hit(tag_type t, logic [CHAN_W-1:0] ch);
      return t.valid && t.in_range && (t.channel == ch);
   endfunction

   assign in_range = int'(req_chan.channel) < CHANNELS;
   assign hazard   = in_range && (tag_hit(s1_tag, req_chan.channel)
                                  || tag_hit(s2_tag, req_chan.channel)
                                  || tag_hit(s3_tag, req_chan.channel));
   assign advance  = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance && !hazard;
   assign accept   = req_chan.valid && req_chan.ready;
   assign in_tag   = '{valid: accept, in_range: in_range, channel: req_chan.channel};

   lir4_hist_mem #(
      .DEPTH  (CHANNELS),
      .ADDR_W (ADDR_W),
      .ROW_W  (ROW_W)
   ) u_hist_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (advance),
      .rd_addr (ADDR_W'(req_chan.channel)),
      .rd_row  (rd_row),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(wr_tag.channel)),
      .wr_row  (wr_row)
   );

   lir4_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_tag      (in_tag),
      .in_sample   (req_chan.sample_in),
      .coefs       (coef_ff),
      .hist_row    (rd_row),
      .s1_tag      (s1_tag),
      .s2_tag      (s2_tag),
      .s3_tag      (s3_tag),
      .wr_tag      (wr_tag),
      .wr_en       (wr_en),
      .wr_row      (wr_row),
      .out_valid   (rsp_chan.valid),
      .out_channel (rsp_chan.channel_out),
      .out_sample  (rsp_chan.sample_out)
   );

   // Interlock keeps at most one item per channel between read and write-back
   a_no_dup_s1_s2: assert property (@(posedge clock) disable iff (reset)
      tag_hit(s1_tag, s1_tag.channel) && tag_hit(s2_tag, s1_tag.channel) |-> 1'b0)
      else $error("two items of one channel in stages 1 and 2");

   a_no_dup_s1_s3: assert property (@(posedge clock) disable iff (reset)
      tag_hit(s1_tag, s1_tag.channel) && tag_hit(s3_tag, s1_tag.channel) |-> 1'b0)
      else $error("two items of one channel in stages 1 and 3");

   // A history write always coincides with a result entering the response register
   a_wr_has_rsp: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_chan.valid)
      else $error("history written without a result");

   // Results for channels beyond the configured count carry a zero sample
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (int'(rsp_chan.channel_out) >= CHANNELS) |-> rsp_chan.sample_out == '0)
      else $error("nonzero sample for an unused channel");

endmodule

// File: test/lir4_highpass_monitor.sv
// Monitor for the Linkwitz-Riley highpass filter: predicts every result and checks the rsp items.
// Depends on lir4_pkg for the register map, coefficient type and field widths.
`timescale 1ns / 1ps

module lir4_highpass_monitor import lir4_pkg::*; #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [CHAN_W-1:0]             req_channel,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [CHAN_W-1:0]             rsp_channel,
   input  logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wr_data,
   output int                            mismatch_count,
   output int                            outstanding
);

   localparam longint SAT_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_MIN    = -SAT_MAX - 1;
   localparam int     REPORT_CAP = 100;

   typedef struct packed {
      logic [CHAN_W-1:0]             channel;
      logic signed [SAMPLE_BITS-1:0] sample;
   } filtered_item_type;

   // Coefficient copy and per-channel histories, newest tap at index 0
   coef_type                      coef_reg [NUM_COEFS];
   logic signed [SAMPLE_BITS-1:0] x_hist [CHANNELS][TAPS];
   logic signed [SAMPLE_BITS-1:0] y_hist [CHANNELS][TAPS];
   filtered_item_type             awaited_outputs [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   // One filter step: exact sum of products, round half up, saturate, shift histories
   function automatic filtered_item_type highpass_step(input logic [CHAN_W-1:0] ch,
                                                       input logic signed [SAMPLE_BITS-1:0] x);
      filtered_item_type res;
      longint            acc;
      longint            rounded;
      int                c;
      int                k;
      res.channel = ch;
      res.sample  = '0;
      if (int'(ch) < CHANNELS) begin
         c   = int'(ch);
         acc = longint'(coef_reg[CSR_A0]) * (longint'(x) + longint'(x_hist[c][3]))
             + longint'(coef_reg[CSR_A1]) * (longint'(x_hist[c][0]) + longint'(x_hist[c][2]))
             + longint'(coef_reg[CSR_A2]) * longint'(x_hist[c][1])
             - longint'(coef_reg[CSR_B1]) * longint'(y_hist[c][0])
             - longint'(coef_reg[CSR_B2]) * longint'(y_hist[c][1])
             - longint'(coef_reg[CSR_B3]) * longint'(y_hist[c][2])
             - longint'(coef_reg[CSR_B4]) * longint'(y_hist[c][3]);
         rounded = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
         if (rounded > SAT_MAX) rounded = SAT_MAX;
         else if (rounded < SAT_MIN) rounded = SAT_MIN;
         res.sample = rounded[SAMPLE_BITS-1:0];
         for (k = TAPS - 1; k > 0; k--) begin
            x_hist[c][k] = x_hist[c][k-1];
            y_hist[c][k] = y_hist[c][k-1];
         end
         x_hist[c][0] = x;
         y_hist[c][0] = res.sample;
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string field, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endtask

   // Everything is sampled at the clock edge, before the block's own updates land
   always @(posedge clock) begin
      filtered_item_type want;
      if (reset) begin
         foreach (coef_reg[i]) coef_reg[i] = '0;
         foreach (x_hist[i, j]) begin
            x_hist[i][j] = '0;
            y_hist[i][j] = '0;
         end
         awaited_outputs.delete();
      end else begin
         // writes past the register map are ignored
         if (csr_wr_en === 1'b1 && csr_index < NUM_COEFS)
            coef_reg[csr_index] = csr_wr_data;
         if (req_valid === 1'b1 && req_ready === 1'b1)
            awaited_outputs.push_back(highpass_step(req_channel, req_sample));
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (awaited_outputs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_CAP)
                  $error("rsp item with no expected result: channel_out %0d, sample_out %0d",
                         rsp_channel, rsp_sample);
            end else begin
               want = awaited_outputs.pop_front();
               if (rsp_channel !== want.channel)
                  flag_mismatch("channel_out", want.channel, rsp_channel);
               if (rsp_sample !== want.sample)
                  flag_mismatch("sample_out", want.sample, rsp_sample);
            end
         end
      end
      outstanding = awaited_outputs.size();
   end

endmodule

// File: test/tb_linkwitz_riley4_highpass_iir_top.sv
// Top of the Linkwitz-Riley highpass testbench: clock, reset, stimulus, flow control and verdict.
// Depends on lir4_pkg, lir4_if, the filter top and lir4_highpass_monitor.
`timescale 1ns / 1ps

module tb_linkwitz_riley4_highpass_iir_top;
   import lir4_pkg::*;

   localparam int CHANNELS      = 8;
   localparam int SAMPLE_BITS   = 24;
   localparam int RESET_CYCLES  = 9;
   localparam int DRAIN_CYCLES  = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 110;
   localparam int SMALL_COEF    = 1 << (COEF_FRAC - 2);

   // first index past the register map; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = CSR_IDX_W'(NUM_COEFS);

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam coef_type COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
   localparam coef_type COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
   localparam coef_type COEF_HALF = coef_type'(1 << (COEF_FRAC - 1));

   typedef coef_type coef_bank_type [NUM_COEFS];
   typedef enum {SET_HIGHPASS, SET_SMALL, SET_FULL, SET_EXTREME} coef_mix_type;

   // Order a0, a1, a2, b1..b4. Fourfold zero at z = 1, fourfold pole at z = 0.5,
   // unity gain at Nyquist.
   localparam coef_bank_type HIGHPASS_SET = '{331776, -1327104, 1990656,
                                              -2097152, 1572864, -524288, 65536};
   localparam coef_mix_type PHASE_MIX [RANDOM_PHASES] =
      '{SET_HIGHPASS, SET_SMALL, SET_FULL, SET_HIGHPASS, SET_SMALL, SET_EXTREME};

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    mismatch_count;
   int                    outstanding;
   int                    cycle_count;
   bit                    burst;
   bit                    hold_request;
   logic [CHAN_W-1:0]     last_channel;

   lir4_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   lir4_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_chan ();

   linkwitz_riley4_highpass_iir_top #(
      .CHANNELS   (CHANNELS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   lir4_highpass_monitor #(
      .CHANNELS   (CHANNELS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) hp_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_channel   (req_chan.channel),
      .req_sample    (req_chan.sample_in),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_channel   (rsp_chan.channel_out),
      .rsp_sample    (rsp_chan.sample_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 8) return SAMPLE_MAX;
      if (r < 16) return SAMPLE_MIN;
      if (r < 30) begin
         v = int'($urandom_range(0, 64)) - 32;
         return v[SAMPLE_BITS-1:0];
      end
      return SAMPLE_BITS'($urandom);
   endfunction

   // Same channel again (exercises the repeat stall), round robin, or any channel
   function automatic logic [CHAN_W-1:0] next_channel();
      int r;
      r = $urandom_range(0, 99);
      if (r >= 55)
         last_channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
      else if (r >= 15)
         last_channel = CHAN_W'((int'(last_channel) + 1) % CHANNELS);
      return last_channel;
   endfunction

   function automatic coef_bank_type random_bank(input coef_mix_type mix);
      coef_bank_type bank;
      bank = HIGHPASS_SET;
      foreach (bank[i]) begin
         case (mix)
            SET_SMALL:
               bank[i] = coef_type'(int'($urandom_range(0, 2 * SMALL_COEF)) - SMALL_COEF);
            SET_FULL:    bank[i] = coef_type'($urandom);
            SET_EXTREME: bank[i] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            default:     ;
         endcase
      end
      return bank;
   endfunction

   // Offer one item, keep it up until taken; valid stays high into the next item unless a gap is drawn
   task automatic send_item(input logic [CHAN_W-1:0] ch,
                            input logic signed [SAMPLE_BITS-1:0] s);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.channel   <= ch;
      req_chan.sample_in <= s;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // Stop offering, wait for every expected result, then let the pipeline settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic load_coefs(input coef_bank_type bank, input bit poke_unmapped);
      int i;
      for (i = 0; i < NUM_COEFS; i++)
         write_reg(csr_index_type'(i), bank[i]);
      if (poke_unmapped)
         write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // Response side flow control; one long hold-off on request
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            gap = burst ? 0 : pick_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int p;
      int n;
      burst              = 1'b0;
      hold_request       = 1'b0;
      last_channel       = '0;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= '0;
      csr_wr_data        <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.channel   <= '0;
      req_chan.sample_in <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Coefficients still zero after reset: everything filters to zero, histories fill
      send_item(0, SAMPLE_MAX);
      send_item(CHANNELS - 1, SAMPLE_MIN);
      send_item(0, 0);
      send_item(0, -1);
      send_item(3, 1);

      // a0 = 0.5 alone: half-way cases round toward plus infinity
      wait_idle();
      load_coefs('{COEF_HALF, 0, 0, 0, 0, 0, 0}, 1'b1);
      send_item(1, 1);
      send_item(1, -1);
      send_item(1, 3);
      send_item(1, -3);
      send_item(2, -1);
      send_item(1, 0);
      send_item(2, 0);

      // Largest coefficients: the sum overflows the sample range both ways
      wait_idle();
      load_coefs('{default: COEF_MAX}, 1'b0);
      send_item(5, SAMPLE_MAX);
      send_item(5, SAMPLE_MAX);
      send_item(6, SAMPLE_MIN);
      send_item(5, SAMPLE_MIN);
      send_item(5, SAMPLE_MIN);

      wait_idle();
      load_coefs('{default: COEF_MIN}, 1'b0);
      send_item(5, SAMPLE_MAX);
      send_item(5, SAMPLE_MIN);
      send_item(6, 0);
      send_item(5, 0);

      // Impulse into a true highpass
      wait_idle();
      load_coefs(HIGHPASS_SET, 1'b0);
      send_item(2, SAMPLE_MAX);
      send_item(2, 0);
      send_item(4, SAMPLE_MIN);
      send_item(2, 0);

      // Random phases, one coefficient mix each; a gap-free stretch in every phase,
      // and in one of them the response side holds off long enough to back up the input
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         load_coefs(random_bank(PHASE_MIX[p]), p == RANDOM_PHASES - 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 30) begin
               burst = 1'b1;
               if (p == 1) hold_request = 1'b1;
            end
            if (n == 70) burst = 1'b0;
            send_item(next_channel(), random_sample());
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
src/lir4_pkg.sv
src/lir4_if.sv
src/lir4_hist_mem.sv
src/lir4_datapath.sv
src/linkwitz_riley4_highpass_iir_top.sv
test/lir4_highpass_monitor.sv
test/tb_linkwitz_riley4_highpass_iir_top.sv
